[rtl/svpwm_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the space vector PWM unit.
// No dependencies; used by the interfaces, svpwm_duty and space_vector_pwm_unit.
package svpwm_pkg;

    localparam int VECTOR_WIDTH_DEF = 16;
    localparam int PERIOD_WIDTH_DEF = 16;
    localparam int PERIOD_RESET     = 1000;
    localparam int SQRT3_HALF_Q16   = 56756;
    localparam int FRAC_WIDTH       = 32;

    typedef enum logic [2:0] {
        SECTOR_0 = 3'd0,
        SECTOR_1 = 3'd1,
        SECTOR_2 = 3'd2,
        SECTOR_3 = 3'd3,
        SECTOR_4 = 3'd4,
        SECTOR_5 = 3'd5
    } sector_t;

    typedef struct packed {
        logic [FRAC_WIDTH-1:0] frac;
        logic                  full;
        logic                  clip;
    } duty_t;

endpackage

[rtl/svpwm_if.sv]
`timescale 1ns / 1ps
// Request channels of the space vector PWM unit: vector in, compares out.
// Depends on svpwm_pkg.
interface svpwm_vec_if #(
    parameter int VECTOR_WIDTH = svpwm_pkg::VECTOR_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [VECTOR_WIDTH-1:0] alpha;
    logic signed [VECTOR_WIDTH-1:0] beta;

    modport source (output valid, output alpha, output beta, input ready);
    modport sink   (input valid, input alpha, input beta, output ready);
endinterface

interface svpwm_cmp_if #(
    parameter int PERIOD_WIDTH = svpwm_pkg::PERIOD_WIDTH_DEF
);
    logic                    valid;
    logic                    ready;
    logic [PERIOD_WIDTH-1:0] compare_u;
    logic [PERIOD_WIDTH-1:0] compare_v;
    logic [PERIOD_WIDTH-1:0] compare_w;
    logic [2:0]              sector;
    logic                    clipped;

    modport source (output valid, output compare_u, output compare_v, output compare_w,
                    output sector, output clipped, input ready);
    modport sink   (input valid, input compare_u, input compare_v, input compare_w,
                    input sector, input clipped, output ready);
endinterface

[rtl/svpwm_duty.sv]
`timescale 1ns / 1ps
// Clamp of one doubled duty fraction to [0, 1] and alignment to 32 fraction bits.
// Depends on svpwm_pkg (duty_t, FRAC_WIDTH).
module svpwm_duty #(
    parameter int VECTOR_WIDTH = svpwm_pkg::VECTOR_WIDTH_DEF
) (
    input  logic signed [VECTOR_WIDTH+19:0] d,
    output svpwm_pkg::duty_t                duty
);
    localparam int DW = VECTOR_WIDTH + 20;
    localparam int SH = VECTOR_WIDTH + 16;
    localparam int FW = svpwm_pkg::FRAC_WIDTH;
    localparam logic signed [DW-1:0] FULL = DW'(1) <<< SH;

    logic          neg;
    logic          at_full;
    logic [SH-1:0] dc;
    logic [FW-1:0] frac;

    assign neg     = d[DW-1];
    assign at_full = !neg && (d >= FULL);
    assign dc      = (neg || at_full) ? '0 : d[SH-1:0];

    generate
        if (SH >= FW)
        begin : g_trunc
            assign frac = dc[SH-1:SH-FW];
        end
        else
        begin : g_extend
            assign frac = {dc, {(FW-SH){1'b0}}};
        end
    endgenerate

    assign duty.frac = frac;
    assign duty.full = at_full;
    assign duty.clip = neg || (d > FULL);

endmodule

[rtl/space_vector_pwm_unit.sv]
`timescale 1ns / 1ps
// Three-phase space vector PWM compare generator, top level.
// Depends on svpwm_pkg, svpwm_if (svpwm_vec_if, svpwm_cmp_if) and svpwm_duty.
//
// Takes one (alpha, beta) vector per clock unless the output stalls, returning
// the U/V/W compare values, sector and clip flag. The pipeline has six register
// stages: squares and alpha*sqrt(3)/2, sector decode, rotated times Tb1/Tb2,
// duty fractions with clamp, period scaling (four parallel period x 32-bit
// multipliers), and phase mapping into the output register. Each stage holds its
// data when the one after it is full and stalled, so bubbles are squeezed out and
// input is taken while a result waits. period is read by the later stages and
// must only be written while no request is in flight.
module space_vector_pwm_unit #(
    parameter int VECTOR_WIDTH = svpwm_pkg::VECTOR_WIDTH_DEF,
    parameter int PERIOD_WIDTH = svpwm_pkg::PERIOD_WIDTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    period_we,
    input  logic [PERIOD_WIDTH-1:0] period_wdata,
    svpwm_vec_if.sink               vec,
    svpwm_cmp_if.source             cmp
);
    localparam int VW = VECTOR_WIDTH;
    localparam int PW = PERIOD_WIDTH;
    localparam int NS = 6;
    localparam int SW = 2 * VW + 2;
    localparam int XW = VW + 17;
    localparam int TW = VW + 19;
    localparam int DW = VW + 20;
    localparam int FW = svpwm_pkg::FRAC_WIDTH;
    localparam logic signed [DW-1:0] ONE = DW'(1) <<< (VW + 15);

    logic [PW-1:0] period_reg;
    logic [NS-1:0] valid_reg;
    logic [NS-1:0] en;

    // stage 0
    logic signed [VW-1:0] b0_reg;
    logic signed [XW-1:0] x0_reg, x0_next;
    logic [SW-1:0]        asq_reg, asq_next, bsq_reg, bsq_next;
    logic                 a_pos_reg, a_neg_reg, b_pos_reg, b_zero_reg, zero0_reg;
    logic signed [2*VW-1:0] asq_s, bsq_s;

    // stage 1
    logic signed [VW-1:0] b1_reg;
    logic signed [XW-1:0] x1_reg;
    svpwm_pkg::sector_t   k1_reg, k1_next;
    logic                 zero1_reg;
    logic                 big;

    // stage 2
    logic signed [TW-1:0] tb1_reg, tb1_next, tb2_reg, tb2_next;
    logic signed [TW-1:0] xe, ye, be;
    svpwm_pkg::sector_t   k2_reg;
    logic                 zero2_reg;

    // stage 3
    logic signed [DW-1:0] d_next [4];
    svpwm_pkg::duty_t     duty_next [4];
    logic [FW-1:0]        frac_reg [4];
    logic [3:0]           full_reg;
    logic                 clip3_reg;
    svpwm_pkg::sector_t   k3_reg;
    logic                 zero3_reg;

    // stage 4
    logic [PW-1:0]        c_reg [4];
    logic [PW-1:0]        c_next [4];
    logic [PW+FW-1:0]     prod [4];
    logic                 clip4_reg;
    svpwm_pkg::sector_t   k4_reg;
    logic                 zero4_reg;

    // stage 5 (output)
    logic [PW-1:0]        cu_reg, cu_next, cv_reg, cv_next, cw_reg, cw_next;
    logic [2:0]           sec_reg, sec_next;
    logic                 clip5_reg, clip5_next;

    always_comb
    begin
        en[NS-1] = !valid_reg[NS-1] || cmp.ready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    assign vec.ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PW'(svpwm_pkg::PERIOD_RESET);
            valid_reg  <= '0;
        end
        else
        begin
            if (period_we)
            begin
                period_reg <= period_wdata;
            end
            if (en[0])
            begin
                valid_reg[0] <= vec.valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (en[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // stage 0: squares for the sector test, alpha * sqrt(3)/2
    assign asq_s    = vec.alpha * vec.alpha;
    assign bsq_s    = vec.beta * vec.beta;
    assign asq_next = SW'($unsigned(asq_s));
    assign bsq_next = SW'($unsigned(bsq_s));
    assign x0_next  = vec.alpha * $signed(18'(svpwm_pkg::SQRT3_HALF_Q16));

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            b0_reg     <= vec.beta;
            x0_reg     <= x0_next;
            asq_reg    <= asq_next;
            bsq_reg    <= bsq_next;
            a_pos_reg  <= !vec.alpha[VW-1] && (vec.alpha != '0);
            a_neg_reg  <= vec.alpha[VW-1];
            b_pos_reg  <= !vec.beta[VW-1] && (vec.beta != '0);
            b_zero_reg <= (vec.beta == '0);
            zero0_reg  <= (vec.alpha == '0) && (vec.beta == '0);
        end
    end

    // stage 1: sector
    assign big = (asq_reg + (asq_reg << 1)) > bsq_reg;

    always_comb
    begin
        if (b_pos_reg || (b_zero_reg && a_pos_reg))
        begin
            if (big && a_pos_reg)
                k1_next = svpwm_pkg::SECTOR_0;
            else if (big && a_neg_reg)
                k1_next = svpwm_pkg::SECTOR_2;
            else
                k1_next = svpwm_pkg::SECTOR_1;
        end
        else
        begin
            if (big && a_neg_reg)
                k1_next = svpwm_pkg::SECTOR_3;
            else if (big && a_pos_reg)
                k1_next = svpwm_pkg::SECTOR_5;
            else
                k1_next = svpwm_pkg::SECTOR_4;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            b1_reg    <= b0_reg;
            x1_reg    <= x0_reg;
            k1_reg    <= k1_next;
            zero1_reg <= zero0_reg;
        end
    end

    // stage 2: rotate back by the sector angle
    assign xe = TW'(x1_reg);
    assign ye = TW'(b1_reg) <<< 15;
    assign be = TW'(b1_reg) <<< 16;

    always_comb
    begin
        unique case (k1_reg)
            svpwm_pkg::SECTOR_0:
            begin
                tb1_next = xe - ye;
                tb2_next = be;
            end
            svpwm_pkg::SECTOR_1:
            begin
                tb1_next = xe + ye;
                tb2_next = ye - xe;
            end
            svpwm_pkg::SECTOR_2:
            begin
                tb1_next = be;
                tb2_next = -ye - xe;
            end
            svpwm_pkg::SECTOR_3:
            begin
                tb1_next = ye - xe;
                tb2_next = -be;
            end
            svpwm_pkg::SECTOR_4:
            begin
                tb1_next = -xe - ye;
                tb2_next = xe - ye;
            end
            default:
            begin
                tb1_next = -be;
                tb2_next = xe + ye;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            tb1_reg   <= tb1_next;
            tb2_reg   <= tb2_next;
            k2_reg    <= k1_reg;
            zero2_reg <= zero1_reg;
        end
    end

    // stage 3: doubled duty fractions t1, t2, t3, T0 and clamp
    assign d_next[0] = ONE + DW'(tb1_reg) + DW'(tb2_reg);
    assign d_next[1] = ONE - DW'(tb1_reg) + DW'(tb2_reg);
    assign d_next[2] = ONE + DW'(tb1_reg) - DW'(tb2_reg);
    assign d_next[3] = ONE - DW'(tb1_reg) - DW'(tb2_reg);

    generate
        for (genvar g = 0; g < 4; g++)
        begin : g_duty
            svpwm_duty #(
                .VECTOR_WIDTH(VW)
            ) u_duty (
                .d   (d_next[g]),
                .duty(duty_next[g])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            for (int i = 0; i < 4; i++)
            begin
                frac_reg[i] <= duty_next[i].frac;
                full_reg[i] <= duty_next[i].full;
            end
            clip3_reg <= duty_next[0].clip || duty_next[1].clip
                      || duty_next[2].clip || duty_next[3].clip;
            k3_reg    <= k2_reg;
            zero3_reg <= zero2_reg;
        end
    end

    // stage 4: scale by period
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            prod[i]   = (PW+FW)'(period_reg) * (PW+FW)'(frac_reg[i]);
            c_next[i] = full_reg[i] ? period_reg : prod[i][PW+FW-1:FW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            for (int i = 0; i < 4; i++)
            begin
                c_reg[i] <= c_next[i];
            end
            clip4_reg <= clip3_reg;
            k4_reg    <= k3_reg;
            zero4_reg <= zero3_reg;
        end
    end

    // stage 5: phase mapping; c_reg order is t1, t2, t3, T0
    always_comb
    begin
        unique case (k4_reg)
            svpwm_pkg::SECTOR_0:
            begin
                cu_next = c_reg[0];
                cv_next = c_reg[1];
                cw_next = c_reg[3];
            end
            svpwm_pkg::SECTOR_1:
            begin
                cu_next = c_reg[2];
                cv_next = c_reg[0];
                cw_next = c_reg[3];
            end
            svpwm_pkg::SECTOR_2:
            begin
                cu_next = c_reg[3];
                cv_next = c_reg[0];
                cw_next = c_reg[1];
            end
            svpwm_pkg::SECTOR_3:
            begin
                cu_next = c_reg[3];
                cv_next = c_reg[2];
                cw_next = c_reg[0];
            end
            svpwm_pkg::SECTOR_4:
            begin
                cu_next = c_reg[1];
                cv_next = c_reg[3];
                cw_next = c_reg[0];
            end
            default:
            begin
                cu_next = c_reg[0];
                cv_next = c_reg[3];
                cw_next = c_reg[2];
            end
        endcase
        sec_next   = k4_reg;
        clip5_next = clip4_reg;
        if (zero4_reg)
        begin
            cu_next    = period_reg >> 1;
            cv_next    = period_reg >> 1;
            cw_next    = period_reg >> 1;
            sec_next   = svpwm_pkg::SECTOR_0;
            clip5_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            cu_reg    <= cu_next;
            cv_reg    <= cv_next;
            cw_reg    <= cw_next;
            sec_reg   <= sec_next;
            clip5_reg <= clip5_next;
        end
    end

    assign cmp.valid     = valid_reg[NS-1];
    assign cmp.compare_u = cu_reg;
    assign cmp.compare_v = cv_reg;
    assign cmp.compare_w = cw_reg;
    assign cmp.sector    = sec_reg;
    assign cmp.clipped   = clip5_reg;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for space_vector_pwm_unit: vector requests in, compare sets out.
// Depends on svpwm_pkg, svpwm_if and the unit RTL; predicts each compare set from the vector.
module testbench;

    localparam int VW           = svpwm_pkg::VECTOR_WIDTH_DEF;
    localparam int PW           = svpwm_pkg::PERIOD_WIDTH_DEF;
    localparam int STALL_LIMIT  = 4000;
    localparam int SETTLE_CYC   = 10;
    localparam int NUM_SEGMENTS = 6;
    localparam int SEG_ITEMS    = 242;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic signed [VW-1:0] alpha;
        logic signed [VW-1:0] beta;
    } vector_t;

    typedef struct packed {
        logic [PW-1:0]       u;
        logic [PW-1:0]       v;
        logic [PW-1:0]       w;
        svpwm_pkg::sector_t  sector;
        logic                clipped;
    } compare_set_t;

    logic clk;
    logic rst_n;
    logic period_we;
    logic [PW-1:0] period_wdata;

    svpwm_vec_if #(.VECTOR_WIDTH(VW)) vec_ch ();
    svpwm_cmp_if #(.PERIOD_WIDTH(PW)) cmp_ch ();

    space_vector_pwm_unit #(
        .VECTOR_WIDTH(VW),
        .PERIOD_WIDTH(PW)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .period_we    (period_we),
        .period_wdata (period_wdata),
        .vec          (vec_ch),
        .cmp          (cmp_ch)
    );

    vector_t      pending_vectors[$];
    compare_set_t expected_compares[$];
    logic [PW-1:0] period_mirror = PW'(svpwm_pkg::PERIOD_RESET);
    logic req_taken = 1'b0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int mismatches = 0;
    int vectors_sent = 0;
    int sets_checked = 0;
    int sets_clipped = 0;
    int stall_cycles = 0;

    function automatic logic [PW-1:0] duty_to_compare(input longint dbl,
                                                      input logic [PW-1:0] per,
                                                      output logic clamped);
        int shift;
        longint full;
        longint unsigned f;
        longint unsigned pr;
        shift = VW - 1 + 17;
        full = longint'(1) << shift;
        clamped = 1'b0;
        if (dbl < 0)
        begin
            dbl = 0;
            clamped = 1'b1;
        end
        if (dbl > full)
        begin
            dbl = full;
            clamped = 1'b1;
        end
        f = dbl;
        if (shift > svpwm_pkg::FRAC_WIDTH)
            f = f >> (shift - svpwm_pkg::FRAC_WIDTH);
        else if (shift < svpwm_pkg::FRAC_WIDTH)
            f = f << (svpwm_pkg::FRAC_WIDTH - shift);
        pr = per;
        return PW'((pr * f) >> svpwm_pkg::FRAC_WIDTH);
    endfunction

    function automatic compare_set_t predict_compares(input vector_t vin,
                                                      input logic [PW-1:0] per);
        longint a, b, x, y, bb, tb1, tb2, one;
        logic [PW-1:0] c1, c2, c3, c0, h;
        logic k1, k2, k3, k0, big;
        svpwm_pkg::sector_t sec;
        compare_set_t r;
        a = vin.alpha;
        b = vin.beta;
        if (a == 0 && b == 0)
        begin
            h = per >> 1;
            r = '{h, h, h, svpwm_pkg::SECTOR_0, 1'b0};
            return r;
        end
        big = (3 * a * a) > (b * b);
        if (b > 0 || (b == 0 && a > 0))
            sec = (big && a > 0) ? svpwm_pkg::SECTOR_0 :
                  (big && a < 0) ? svpwm_pkg::SECTOR_2 : svpwm_pkg::SECTOR_1;
        else
            sec = (big && a < 0) ? svpwm_pkg::SECTOR_3 :
                  (big && a > 0) ? svpwm_pkg::SECTOR_5 : svpwm_pkg::SECTOR_4;
        x  = a * svpwm_pkg::SQRT3_HALF_Q16;
        y  = b * 32768;
        bb = b * 65536;
        case (sec)
            svpwm_pkg::SECTOR_0: begin tb1 = x - y;  tb2 = bb;     end
            svpwm_pkg::SECTOR_1: begin tb1 = x + y;  tb2 = y - x;  end
            svpwm_pkg::SECTOR_2: begin tb1 = bb;     tb2 = -y - x; end
            svpwm_pkg::SECTOR_3: begin tb1 = y - x;  tb2 = -bb;    end
            svpwm_pkg::SECTOR_4: begin tb1 = -x - y; tb2 = x - y;  end
            default:             begin tb1 = -bb;    tb2 = x + y;  end
        endcase
        one = longint'(1) << (VW - 1 + 16);
        c1 = duty_to_compare(one + tb1 + tb2, per, k1);
        c2 = duty_to_compare(one - tb1 + tb2, per, k2);
        c3 = duty_to_compare(one + tb1 - tb2, per, k3);
        c0 = duty_to_compare(one - tb1 - tb2, per, k0);
        case (sec)
            svpwm_pkg::SECTOR_0: begin r.u = c1; r.v = c2; r.w = c0; end
            svpwm_pkg::SECTOR_1: begin r.u = c3; r.v = c1; r.w = c0; end
            svpwm_pkg::SECTOR_2: begin r.u = c0; r.v = c1; r.w = c2; end
            svpwm_pkg::SECTOR_3: begin r.u = c0; r.v = c3; r.w = c1; end
            svpwm_pkg::SECTOR_4: begin r.u = c2; r.v = c0; r.w = c1; end
            default:             begin r.u = c1; r.v = c0; r.w = c3; end
        endcase
        r.sector  = sec;
        r.clipped = k1 | k2 | k3 | k0;
        return r;
    endfunction

    task automatic push_vec(input longint a, input longint b);
        vector_t item;
        item.alpha = a[VW-1:0];
        item.beta  = b[VW-1:0];
        pending_vectors.push_back(item);
    endtask

    task automatic wait_drained();
        while (pending_vectors.size() != 0 || vec_ch.valid || expected_compares.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
            vec_ch.valid <= 1'b0;
        else if (!vec_ch.valid || req_taken)
        begin
            if (pending_vectors.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
            begin
                vec_ch.alpha <= pending_vectors[0].alpha;
                vec_ch.beta  <= pending_vectors[0].beta;
                vec_ch.valid <= 1'b1;
                void'(pending_vectors.pop_front());
            end
            else
                vec_ch.valid <= 1'b0;
        end
    end

    always @(negedge clk)
        cmp_ch.ready <= rst_n && ($urandom_range(0, 99) >= rx_idle_pct);

    // monitor
    always @(posedge clk)
    begin
        compare_set_t seen;
        compare_set_t want;
        logic in_acc;
        logic out_acc;
        in_acc  = rst_n && vec_ch.valid && vec_ch.ready;
        out_acc = rst_n && cmp_ch.valid && cmp_ch.ready;
        req_taken <= in_acc;
        if (out_acc)
        begin
            seen = '{cmp_ch.compare_u, cmp_ch.compare_v, cmp_ch.compare_w,
                     svpwm_pkg::sector_t'(cmp_ch.sector), cmp_ch.clipped};
            if (expected_compares.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("mismatch: unexpected compare set u=%0d v=%0d w=%0d s=%0d c=%0b",
                             seen.u, seen.v, seen.w, seen.sector, seen.clipped);
            end
            else
            begin
                want = expected_compares.pop_front();
                sets_checked++;
                if (want.clipped)
                    sets_clipped++;
                if (seen !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"mismatch: exp u=%0d v=%0d w=%0d s=%0d c=%0b, ",
                                  "got u=%0d v=%0d w=%0d s=%0d c=%0b"},
                                 want.u, want.v, want.w, want.sector, want.clipped,
                                 seen.u, seen.v, seen.w, seen.sector, seen.clipped);
                end
            end
        end
        if (in_acc)
        begin
            expected_compares.push_back(predict_compares({vec_ch.alpha, vec_ch.beta},
                                                         period_mirror));
            vectors_sent++;
        end
        if (!rst_n)
            period_mirror <= PW'(svpwm_pkg::PERIOD_RESET);
        else if (period_we)
            period_mirror <= period_wdata;
        if (in_acc || out_acc)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no request accepted for %0d cycles", STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int seg;
        int i;
        int mode;
        longint ta;
        longint tb;
        longint corner[6];
        logic [PW-1:0] seg_period[NUM_SEGMENTS];

        corner = '{-32768, -32767, -1, 0, 1, 32767};
        seg_period[0] = PW'(svpwm_pkg::PERIOD_RESET);
        seg_period[1] = 16'hFFFF;
        seg_period[2] = 16'd1;
        seg_period[3] = PW'($urandom_range(2, 65534));
        seg_period[4] = 16'd0;
        seg_period[5] = PW'($urandom_range(2, 65534));

        rst_n        = 1'b0;
        period_we    = 1'b0;
        period_wdata = '0;
        vec_ch.valid = 1'b0;
        vec_ch.alpha = '0;
        vec_ch.beta  = '0;
        cmp_ch.ready = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (seg = 0; seg < NUM_SEGMENTS; seg++)
        begin
            wait_drained();
            repeat (SETTLE_CYC) @(negedge clk);
            tx_idle_pct = (seg < 2) ? 33 : (seg < 4) ? 76 : 0;
            rx_idle_pct = (seg < 2) ? 76 : (seg < 4) ? 33 : 0;
            if (seg != 0)
            begin
                period_we    <= 1'b1;
                period_wdata <= seg_period[seg];
                @(negedge clk);
                period_we    <= 1'b0;
                @(negedge clk);
            end
            if (seg == 0)
            begin
                push_vec(0, 0);
                push_vec(32767, 0);
                push_vec(-32768, 0);
                push_vec(0, 32767);
                push_vec(0, -32768);
                push_vec(32767, 32767);
                push_vec(-32768, -32768);
                push_vec(32767, -32768);
                push_vec(-32768, 32767);
                push_vec(1, 0);
                push_vec(-1, 0);
                push_vec(0, 1);
                push_vec(0, -1);
                push_vec(13856, 8000);
                push_vec(0, 16000);
                push_vec(-13856, 8000);
                push_vec(-13856, -8000);
                push_vec(0, -16000);
                push_vec(13856, -8000);
                push_vec(18918, 32767);
                push_vec(18919, 32767);
                push_vec(-18919, -32767);
                push_vec(16384, 0);
                push_vec(-1, -1);
            end
            for (i = 0; i < SEG_ITEMS; i++)
            begin
                mode = $urandom_range(0, 99);
                if (mode < 55)
                begin
                    ta = $signed(16'($urandom));
                    tb = $signed(16'($urandom));
                end
                else if (mode < 70)
                begin
                    ta = longint'($urandom_range(0, 64)) - 32;
                    tb = longint'($urandom_range(0, 64)) - 32;
                end
                else if (mode < 80)
                begin
                    ta = $signed(16'($urandom));
                    tb = 0;
                    if ($urandom_range(0, 1))
                    begin
                        tb = ta;
                        ta = 0;
                    end
                    if ($urandom_range(0, 9) == 0)
                        tb = 0;
                end
                else if (mode < 93)
                begin
                    // hug the 60/120/240/300 degree lines, beta ~ +-sqrt3*alpha
                    ta = longint'($urandom_range(0, 37836)) - 18918;
                    tb = ((ta * 113512) >>> 16) + longint'($urandom_range(0, 4)) - 2;
                    if ($urandom_range(0, 1))
                        tb = -tb;
                    if (tb > 32767)
                        tb = 32767;
                    if (tb < -32768)
                        tb = -32768;
                end
                else
                begin
                    ta = corner[$urandom_range(0, 5)];
                    tb = corner[$urandom_range(0, 5)];
                end
                push_vec(ta, tb);
            end
        end

        wait_drained();
        repeat (2 * SETTLE_CYC) @(negedge clk);
        $display("summary: %0d vectors over %0d period settings, %0d compare sets checked",
                 vectors_sent, NUM_SEGMENTS, sets_checked);
        $display("summary: %0d sets clipped, %0d mismatches", sets_clipped, mismatches);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
